// ===== src/mrw_pkg.sv =====
package mrw_pkg;

    localparam int CAND_BITS     = 64;
    localparam int RND_BITS      = 31;
    localparam int WORD_BITS_DEF = 64;
    localparam int S_TDATA_BITS  = 96;
    localparam int M_TDATA_BITS  = 72;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FACTOR,
        ST_POW_CHECK,
        ST_POW_MUL_R,
        ST_POW_MUL_B,
        ST_CHECK,
        ST_SQ_CHECK,
        ST_SQ_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== src/mrw_mulmod.sv =====
module mrw_mulmod
    import mrw_pkg::*;
#(
    parameter int W = WORD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;

    logic [W-1:0]  addend;
    logic [W:0]    sum;
    logic [W:0]    reduced;

    // One modular addition per cycle: doubling, then adding a when the bit is set.
    always_comb
    begin
        addend  = phase_reg ? a_reg : acc_reg;
        sum     = {1'b0, acc_reg} + {1'b0, addend};
        reduced = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = CW'(W);
            acc_next   = '0;
            a_next     = a;
            b_next     = b;
            m_next     = m;
        end
        else if (busy_reg)
        begin
            acc_next = reduced[W-1:0];
            if (!phase_reg && b_reg[W-1])
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                b_next     = {b_reg[W-2:0], 1'b0};
                cnt_next   = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== src/miller_rabin_witness_test.sv =====
// One Miller-Rabin round on a candidate n with a witness drawn from a random value.
// Input channel s_*: one transfer carries the candidate and the random value.
// Output channel m_*: one transfer per input carries the verdict and the witness used.
// Only the low WORD_BITS bits of the candidate take part; the witness is zero-extended.
// A candidate below 4 is answered directly, without the divide or power steps, with witness 0.
// Otherwise the witness is formed by a bit-serial remainder of the random value, n-1 is
// factored one bit per cycle, and the power and squarings run on one bit-serial
// modular multiplier. Each multiplication doubles once per bit of the multiplier
// operand and adds once more per set bit. A full test needs up to about 2W multiplications.
// One item is in work at a time; s_tready is high only while the block is idle.
// The result waits in an output register, so a new item is taken while the
// receiver stalls; the next result then waits until the register is free.
// Reset clears the controller and the output valid flag; no item is kept.
module miller_rabin_witness_test
    import mrw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // candidate[63:0], random_value[94:64], zero pad
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata    // is_composite[0], witness_used[64:1], zero pad
);

    localparam int W   = WORD_BITS;
    localparam int SW  = $clog2(W);
    localparam int DCW = $clog2(RND_BITS);

    state_t state_reg, state_next;

    logic [W-1:0]        n_reg, n_next;
    logic [W-1:0]        nm1_reg, nm1_next;
    logic [W-1:0]        nm3_reg, nm3_next;
    logic [RND_BITS-1:0] rnd_reg, rnd_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;
    logic [W-1:0]        d_reg, d_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [SW-1:0]       r_reg, r_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        base_reg, base_next;
    logic [W-1:0]        wit_reg, wit_next;
    logic                comp_reg, comp_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0] m_data_reg, m_data_next;

    logic [W-1:0] cand_w;
    logic         cand_tiny;
    logic [W:0]   shifted;
    logic [W:0]   rem_step;
    logic [W-1:0] witness_new;
    logic         out_free;
    logic         x_hit;

    logic         mul_start;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic         mul_busy;
    logic         mul_done;
    logic [W-1:0] mul_res;

    always_comb
    begin
        cand_w      = s_tdata[W-1:0];
        cand_tiny   = (cand_w[W-1:2] == '0);
        shifted     = {rem_reg, rnd_reg[RND_BITS-1]};
        rem_step    = (shifted >= {1'b0, nm3_reg}) ? shifted - {1'b0, nm3_reg} : shifted;
        witness_new = rem_step[W-1:0] + W'(2);
        out_free    = !m_valid_reg || m_tready;
        x_hit       = (x_reg == W'(1)) || (x_reg == nm1_reg);
    end

    mrw_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (n_reg),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cand_tiny ? ST_DONE : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_cnt_reg == DCW'(RND_BITS - 1))
                begin
                    state_next = ST_FACTOR;
                end
            end
            ST_FACTOR:
            begin
                if (d_reg[0])
                begin
                    state_next = ST_POW_CHECK;
                end
            end
            ST_POW_CHECK:
            begin
                if (d_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = d_reg[0] ? ST_POW_MUL_R : ST_POW_MUL_B;
                end
            end
            ST_POW_MUL_R:
            begin
                if (mul_done)
                begin
                    state_next = ST_POW_MUL_B;
                end
            end
            ST_POW_MUL_B:
            begin
                if (mul_done)
                begin
                    state_next = ST_POW_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = x_hit ? ST_DONE : ST_SQ_CHECK;
            end
            ST_SQ_CHECK:
            begin
                state_next = (r_reg < s_reg) ? ST_SQ_WAIT : ST_DONE;
            end
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (mul_res == nm1_reg) ? ST_DONE : ST_SQ_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        mul_start    = 1'b0;
        mul_a        = base_reg;
        mul_b        = base_reg;
        n_next       = n_reg;
        nm1_next     = nm1_reg;
        nm3_next     = nm3_reg;
        rnd_next     = rnd_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        d_next       = d_reg;
        s_next       = s_reg;
        r_next       = r_reg;
        x_next       = x_reg;
        base_next    = base_reg;
        wit_next     = wit_reg;
        comp_next    = comp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next       = cand_w;
                    nm1_next     = cand_w - W'(1);
                    nm3_next     = cand_w - W'(3);
                    d_next       = cand_w - W'(1);
                    rnd_next     = s_tdata[CAND_BITS +: RND_BITS];
                    rem_next     = '0;
                    div_cnt_next = '0;
                    s_next       = '0;
                    r_next       = SW'(1);
                    x_next       = W'(1);
                    wit_next     = '0;
                    comp_next    = !((cand_w == W'(2)) || (cand_w == W'(3)));
                end
            end
            ST_DIVIDE:
            begin
                rem_next     = rem_step[W-1:0];
                rnd_next     = {rnd_reg[RND_BITS-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DCW'(1);
                base_next    = witness_new;
                wit_next     = witness_new;
            end
            ST_FACTOR:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    s_next = s_reg + SW'(1);
                end
            end
            ST_POW_CHECK:
            begin
                if (d_reg != '0)
                begin
                    mul_start = 1'b1;
                    mul_a     = d_reg[0] ? x_reg : base_reg;
                end
            end
            ST_POW_MUL_R:
            begin
                if (mul_done)
                begin
                    x_next    = mul_res;
                    mul_start = 1'b1;
                end
            end
            ST_POW_MUL_B:
            begin
                if (mul_done)
                begin
                    base_next = mul_res;
                    d_next    = {1'b0, d_reg[W-1:1]};
                end
            end
            ST_CHECK:
            begin
                if (x_hit)
                begin
                    comp_next = 1'b0;
                end
            end
            ST_SQ_CHECK:
            begin
                if (r_reg < s_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = x_reg;
                    mul_b     = x_reg;
                end
            end
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    x_next = mul_res;
                    r_next = r_reg + SW'(1);
                    if (mul_res == nm1_reg)
                    begin
                        comp_next = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, 64'(wit_reg), comp_reg};
                end
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        nm1_reg     <= nm1_next;
        nm3_reg     <= nm3_next;
        rnd_reg     <= rnd_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        d_reg       <= d_next;
        s_reg       <= s_next;
        r_reg       <= r_next;
        x_reg       <= x_next;
        base_reg    <= base_next;
        wit_reg     <= wit_next;
        comp_reg    <= comp_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (x_reg < n_reg))
        else $error("power result not reduced");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POW_CHECK) |-> (base_reg < n_reg))
        else $error("base not reduced");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ_CHECK) |-> (r_reg != '0))
        else $error("squaring count lost");

endmodule
